[sv/aqg_pkg.sv]
// Package with the shared types and codes of the anchor quality gate.
package aqg_pkg;

    typedef enum logic [2:0] {
        REJ_NONE      = 3'd0,
        REJ_TELEMETRY = 3'd1,
        REJ_RANGE     = 3'd2,
        REJ_GNSS      = 3'd3,
        REJ_SIGMA     = 3'd4
    } reject_t;

    typedef enum logic [1:0] {
        REG_TELEMETRY_TTL = 2'd0,
        REG_RANGE_TTL     = 2'd1,
        REG_MAX_SIGMA     = 2'd2,
        REG_MIN_FIX       = 2'd3
    } reg_idx_t;

    localparam logic [2:0] MIN_FIX_RESET = 3'd3;

    typedef struct packed {
        logic [31:0] telemetry_ttl;
        logic [31:0] range_ttl;
        logic [31:0] max_sigma;
        logic [2:0]  min_fix;
    } cfg_t;

    typedef struct packed {
        logic [31:0] now_time;
        logic [31:0] telemetry_time;
        logic [31:0] range_time;
        logic        peer_present;
        logic        gnss_ok;
        logic [2:0]  fix_kind;
        logic        range_ok;
        logic [31:0] range_dist;
        logic [31:0] range_sigma;
    } in_item_t;

    typedef struct packed {
        reject_t code;
        logic    t_one;
        logic    r_one;
    } side_t;

endpackage

[sv/aqg_front.sv]
// Check stage: computes ages, the reject code and the starting division remainders.
module aqg_front (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  aqg_pkg::in_item_t in_item,
    input  aqg_pkg::cfg_t   cfg,
    output logic            out_valid,
    input  logic            out_ready,
    output aqg_pkg::side_t  out_side,
    output logic [31:0]     out_rem_t,
    output logic [31:0]     out_rem_r
);
    import aqg_pkg::*;

    logic        valid_reg;
    logic        valid_next;
    side_t       side_reg;
    side_t       side_next;
    logic [31:0] rem_t_reg;
    logic [31:0] rem_t_next;
    logic [31:0] rem_r_reg;
    logic [31:0] rem_r_next;
    logic [31:0] t_age;
    logic [31:0] r_age;
    logic        load;

    assign in_ready   = !valid_reg || out_ready;
    assign load       = in_valid && in_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_comb begin
        t_age = in_item.now_time - in_item.telemetry_time;
        r_age = in_item.now_time - in_item.range_time;
        if (!in_item.peer_present) begin
            side_next.code = REJ_TELEMETRY;
        end else if (cfg.telemetry_ttl != 32'd0 && t_age > cfg.telemetry_ttl) begin
            side_next.code = REJ_TELEMETRY;
        end else if (cfg.range_ttl != 32'd0 && r_age > cfg.range_ttl) begin
            side_next.code = REJ_RANGE;
        end else if (!in_item.gnss_ok || in_item.fix_kind < cfg.min_fix) begin
            side_next.code = REJ_GNSS;
        end else if (!in_item.range_ok || in_item.range_dist == 32'd0) begin
            side_next.code = REJ_RANGE;
        end else if (cfg.max_sigma != 32'd0 && in_item.range_sigma > cfg.max_sigma) begin
            side_next.code = REJ_SIGMA;
        end else begin
            side_next.code = REJ_NONE;
        end
        side_next.t_one = (cfg.telemetry_ttl == 32'd0) || (t_age == 32'd0);
        side_next.r_one = (cfg.range_ttl == 32'd0) || (r_age == 32'd0);
        rem_t_next = cfg.telemetry_ttl - t_age;
        rem_r_next = cfg.range_ttl - r_age;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            side_reg  <= side_next;
            rem_t_reg <= rem_t_next;
            rem_r_reg <= rem_r_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_side  = side_reg;
    assign out_rem_t = rem_t_reg;
    assign out_rem_r = rem_r_reg;

endmodule

[sv/aqg_div_cell.sv]
// Division cell: produces one quotient bit of both freshness divisions.
module aqg_div_cell #(
    parameter int QW = 16
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic [31:0]     ttl_t,
    input  logic [31:0]     ttl_r,
    input  logic            in_valid,
    output logic            in_ready,
    input  aqg_pkg::side_t  in_side,
    input  logic [31:0]     in_rem_t,
    input  logic [31:0]     in_rem_r,
    input  logic [QW-1:0]   in_q_t,
    input  logic [QW-1:0]   in_q_r,
    output logic            out_valid,
    input  logic            out_ready,
    output aqg_pkg::side_t  out_side,
    output logic [31:0]     out_rem_t,
    output logic [31:0]     out_rem_r,
    output logic [QW-1:0]   out_q_t,
    output logic [QW-1:0]   out_q_r
);
    import aqg_pkg::*;

    logic          valid_reg;
    logic          valid_next;
    side_t         side_reg;
    logic [31:0]   rem_t_reg;
    logic [31:0]   rem_t_next;
    logic [31:0]   rem_r_reg;
    logic [31:0]   rem_r_next;
    logic [QW-1:0] q_t_reg;
    logic [QW-1:0] q_t_next;
    logic [QW-1:0] q_r_reg;
    logic [QW-1:0] q_r_next;
    logic [32:0]   step_t;
    logic [32:0]   step_r;
    logic          load;

    // One restoring step: returns the quotient bit above the new remainder.
    function automatic logic [32:0] div_step(input logic [31:0] rem, input logic [31:0] ttl);
        logic [32:0] shifted;
        logic [32:0] diff;
        shifted = {rem, 1'b0};
        diff    = shifted - {1'b0, ttl};
        if (shifted >= {1'b0, ttl}) begin
            div_step = {1'b1, diff[31:0]};
        end else begin
            div_step = {1'b0, shifted[31:0]};
        end
    endfunction

    assign in_ready   = !valid_reg || out_ready;
    assign load       = in_valid && in_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_comb begin
        step_t     = div_step(in_rem_t, ttl_t);
        step_r     = div_step(in_rem_r, ttl_r);
        rem_t_next = step_t[31:0];
        rem_r_next = step_r[31:0];
        q_t_next   = {in_q_t[QW-2:0], step_t[32]};
        q_r_next   = {in_q_r[QW-2:0], step_r[32]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            side_reg  <= in_side;
            rem_t_reg <= rem_t_next;
            rem_r_reg <= rem_r_next;
            q_t_reg   <= q_t_next;
            q_r_reg   <= q_r_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_side  = side_reg;
    assign out_rem_t = rem_t_reg;
    assign out_rem_r = rem_r_reg;
    assign out_q_t   = q_t_reg;
    assign out_q_r   = q_r_reg;

endmodule

[sv/aqg_back.sv]
// Score stage: forms the freshness values, multiplies them and holds the result.
module aqg_back #(
    parameter int FRAC_BITS = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  aqg_pkg::side_t       in_side,
    input  logic [FRAC_BITS-1:0] in_q_t,
    input  logic [FRAC_BITS-1:0] in_q_r,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [FRAC_BITS:0]   gnss_score,
    output logic [FRAC_BITS:0]   telemetry_score,
    output logic [FRAC_BITS:0]   range_score,
    output logic [FRAC_BITS:0]   total_score,
    output aqg_pkg::reject_t     reject_code
);
    import aqg_pkg::*;

    localparam int SW = FRAC_BITS + 1;
    localparam logic [SW-1:0] Q_ONE = SW'(1) << FRAC_BITS;

    logic          a_valid_reg;
    logic          a_valid_next;
    logic          a_ready;
    logic          a_load;
    logic [SW-1:0] a_tq_reg;
    logic [SW-1:0] a_tq_next;
    logic [SW-1:0] a_rq_reg;
    logic [SW-1:0] a_rq_next;
    reject_t       a_code_reg;

    logic          b_valid_reg;
    logic          b_valid_next;
    logic          b_ready;
    logic          b_load;
    logic [SW-1:0] b_gnss_reg;
    logic [SW-1:0] b_tq_reg;
    logic [SW-1:0] b_rq_reg;
    logic [SW-1:0] b_total_reg;
    reject_t       b_code_reg;
    logic [2*SW-1:0] product;

    assign b_ready      = !b_valid_reg || out_ready;
    assign b_load       = a_valid_reg && b_ready;
    assign b_valid_next = b_ready ? a_valid_reg : b_valid_reg;

    assign a_ready      = !a_valid_reg || b_ready;
    assign a_load       = in_valid && a_ready;
    assign a_valid_next = a_ready ? in_valid : a_valid_reg;
    assign in_ready     = a_ready;

    always_comb begin
        if (in_side.code != REJ_NONE) begin
            a_tq_next = '0;
            a_rq_next = '0;
        end else begin
            a_tq_next = in_side.t_one ? Q_ONE : {1'b0, in_q_t};
            a_rq_next = in_side.r_one ? Q_ONE : {1'b0, in_q_r};
        end
        product = a_tq_reg * a_rq_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_load) begin
            a_tq_reg   <= a_tq_next;
            a_rq_reg   <= a_rq_next;
            a_code_reg <= in_side.code;
        end
        if (b_load) begin
            b_gnss_reg  <= (a_code_reg == REJ_NONE) ? Q_ONE : '0;
            b_tq_reg    <= a_tq_reg;
            b_rq_reg    <= a_rq_reg;
            b_total_reg <= product[FRAC_BITS +: SW];
            b_code_reg  <= a_code_reg;
        end
    end

    assign out_valid       = b_valid_reg;
    assign gnss_score      = b_gnss_reg;
    assign telemetry_score = b_tq_reg;
    assign range_score     = b_rq_reg;
    assign total_score     = b_total_reg;
    assign reject_code     = b_code_reg;

endmodule

[sv/anchor_quality_gate.sv]
// Top level of the anchor quality gate: register port, check stage, division chain, score stage.
// The gate takes one anchor report per clock while no stage is stalled and returns one scored
// result per report, in order. Both freshness quotients are formed by a row of FRAC_BITS
// restoring cells, one quotient bit per cell, between a check stage in front and a multiply
// stage and an output register behind. Each stage holds its report while the next one is
// full, so empty stages still take new reports while a result waits to be taken. Registers
// must be written over the APB port only while no report is in flight; the block itself
// does not enforce this.
module anchor_quality_gate #(
    parameter int FRAC_BITS = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    input  logic         s_tvalid,
    output logic         s_tready,
    // now_time, telemetry_time, range_time, peer_present, gnss_ok, fix_kind,
    // range_ok, range_dist, range_sigma, zero fill
    input  logic [167:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // gnss_score, telemetry_score, range_score, total_score, reject_code, zero fill
    output logic [((4*(FRAC_BITS+1)+3+7)/8)*8-1:0] m_tdata
);
    import aqg_pkg::*;

    localparam int SW  = FRAC_BITS + 1;
    localparam int MW  = ((4*SW + 3 + 7) / 8) * 8;
    localparam int PAD = MW - (4*SW + 3);

    logic [31:0] telemetry_ttl_reg;
    logic [31:0] range_ttl_reg;
    logic [31:0] max_sigma_reg;
    logic [2:0]  min_fix_reg;
    logic        wr_en;
    reg_idx_t    wr_idx;
    reg_idx_t    rd_idx;
    cfg_t        cfg;
    in_item_t    item;

    logic                 c_valid [0:FRAC_BITS];
    logic                 c_ready [0:FRAC_BITS];
    side_t                c_side  [0:FRAC_BITS];
    logic [31:0]          c_rem_t [0:FRAC_BITS];
    logic [31:0]          c_rem_r [0:FRAC_BITS];
    logic [FRAC_BITS-1:0] c_q_t   [0:FRAC_BITS];
    logic [FRAC_BITS-1:0] c_q_r   [0:FRAC_BITS];

    logic [SW-1:0] gnss_score;
    logic [SW-1:0] telemetry_score;
    logic [SW-1:0] range_score;
    logic [SW-1:0] total_score;
    reject_t       reject_code;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign wr_idx = reg_idx_t'(paddr[3:2]);
    assign rd_idx = reg_idx_t'(paddr[3:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            telemetry_ttl_reg <= '0;
            range_ttl_reg     <= '0;
            max_sigma_reg     <= '0;
            min_fix_reg       <= MIN_FIX_RESET;
        end else if (wr_en) begin
            unique case (wr_idx)
                REG_TELEMETRY_TTL: telemetry_ttl_reg <= pwdata;
                REG_RANGE_TTL:     range_ttl_reg     <= pwdata;
                REG_MAX_SIGMA:     max_sigma_reg     <= pwdata;
                REG_MIN_FIX:       min_fix_reg       <= pwdata[2:0];
                default:           ;
            endcase
        end
    end

    always_comb begin
        unique case (rd_idx)
            REG_TELEMETRY_TTL: prdata = telemetry_ttl_reg;
            REG_RANGE_TTL:     prdata = range_ttl_reg;
            REG_MAX_SIGMA:     prdata = max_sigma_reg;
            REG_MIN_FIX:       prdata = {29'd0, min_fix_reg};
            default:           prdata = '0;
        endcase
    end

    assign cfg.telemetry_ttl = telemetry_ttl_reg;
    assign cfg.range_ttl     = range_ttl_reg;
    assign cfg.max_sigma     = max_sigma_reg;
    assign cfg.min_fix       = min_fix_reg;

    assign item.now_time       = s_tdata[31:0];
    assign item.telemetry_time = s_tdata[63:32];
    assign item.range_time     = s_tdata[95:64];
    assign item.peer_present   = s_tdata[96];
    assign item.gnss_ok        = s_tdata[97];
    assign item.fix_kind       = s_tdata[100:98];
    assign item.range_ok       = s_tdata[101];
    assign item.range_dist     = s_tdata[133:102];
    assign item.range_sigma    = s_tdata[165:134];

    aqg_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_item   (item),
        .cfg       (cfg),
        .out_valid (c_valid[0]),
        .out_ready (c_ready[0]),
        .out_side  (c_side[0]),
        .out_rem_t (c_rem_t[0]),
        .out_rem_r (c_rem_r[0])
    );

    assign c_q_t[0] = '0;
    assign c_q_r[0] = '0;

    for (genvar k = 0; k < FRAC_BITS; k++) begin : g_cell
        aqg_div_cell #(
            .QW (FRAC_BITS)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ttl_t     (telemetry_ttl_reg),
            .ttl_r     (range_ttl_reg),
            .in_valid  (c_valid[k]),
            .in_ready  (c_ready[k]),
            .in_side   (c_side[k]),
            .in_rem_t  (c_rem_t[k]),
            .in_rem_r  (c_rem_r[k]),
            .in_q_t    (c_q_t[k]),
            .in_q_r    (c_q_r[k]),
            .out_valid (c_valid[k+1]),
            .out_ready (c_ready[k+1]),
            .out_side  (c_side[k+1]),
            .out_rem_t (c_rem_t[k+1]),
            .out_rem_r (c_rem_r[k+1]),
            .out_q_t   (c_q_t[k+1]),
            .out_q_r   (c_q_r[k+1])
        );
    end

    aqg_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .in_valid        (c_valid[FRAC_BITS]),
        .in_ready        (c_ready[FRAC_BITS]),
        .in_side         (c_side[FRAC_BITS]),
        .in_q_t          (c_q_t[FRAC_BITS]),
        .in_q_r          (c_q_r[FRAC_BITS]),
        .out_valid       (m_tvalid),
        .out_ready       (m_tready),
        .gnss_score      (gnss_score),
        .telemetry_score (telemetry_score),
        .range_score     (range_score),
        .total_score     (total_score),
        .reject_code     (reject_code)
    );

    assign m_tdata = {{PAD{1'b0}}, reject_code, total_score, range_score,
                      telemetry_score, gnss_score};

endmodule

[sv/aqg_checker.sv]
// Port checker for the anchor quality gate and its bind statement.
module aqg_port_checker #(
    parameter int FRAC_BITS = 16
) (
    input logic aclk,
    input logic aresetn,
    input logic m_tvalid,
    input logic m_tready,
    input logic [((4*(FRAC_BITS+1)+3+7)/8)*8-1:0] m_tdata
);
    import aqg_pkg::*;

    localparam int SW = FRAC_BITS + 1;
    localparam logic [SW-1:0] Q_ONE = SW'(1) << FRAC_BITS;

    logic [SW-1:0] gnss_f;
    logic [SW-1:0] tele_f;
    logic [SW-1:0] range_f;
    logic [SW-1:0] total_f;
    logic [2:0]    code_f;

    assign gnss_f  = m_tdata[0 +: SW];
    assign tele_f  = m_tdata[SW +: SW];
    assign range_f = m_tdata[2*SW +: SW];
    assign total_f = m_tdata[3*SW +: SW];
    assign code_f  = m_tdata[4*SW +: 3];

    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    a_reject_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && code_f != REJ_NONE |-> gnss_f == '0 && tele_f == '0 &&
        range_f == '0 && total_f == '0)
        else $error("rejected report carries scores");

    a_accept_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && code_f == REJ_NONE |-> gnss_f == Q_ONE && tele_f <= Q_ONE &&
        range_f <= Q_ONE)
        else $error("accepted report has bad scores");

    a_total_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> total_f <= tele_f && total_f <= range_f)
        else $error("total score above a freshness score");

endmodule

bind anchor_quality_gate aqg_port_checker #(
    .FRAC_BITS (FRAC_BITS)
) u_aqg_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

[sim/aqg_checker.sv]
// Checker that predicts each anchor report score from the observed requests and compares results and register reads.
`timescale 1ns / 1ps

module aqg_checker #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    psel,
    input  logic                                    penable,
    input  logic                                    pwrite,
    input  logic [3:0]                              paddr,
    input  logic [31:0]                             pwdata,
    input  logic [31:0]                             prdata,
    input  logic                                    pready,
    input  logic                                    s_tvalid,
    input  logic                                    s_tready,
    input  logic [167:0]                            s_tdata,
    input  logic                                    m_tvalid,
    input  logic                                    m_tready,
    input  logic [((4*(FRAC_BITS+1)+3+7)/8)*8-1:0]  m_tdata,
    output int                                      mismatch_count,
    output int                                      pending_count
);
    import aqg_pkg::*;

    localparam int SW = FRAC_BITS + 1;

    typedef struct packed {
        logic [SW-1:0] gnss_score;
        logic [SW-1:0] telemetry_score;
        logic [SW-1:0] range_score;
        logic [SW-1:0] total_score;
        reject_t       code;
    } score_t;

    cfg_t   gate_cfg;
    score_t expected_scores[$];

    initial begin
        mismatch_count = 0;
        pending_count  = 0;
    end

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        mismatch_count++;
        if (mismatch_count <= 40) begin
            $display("MISMATCH at %0t ns: %s got 0x%0h expected 0x%0h", $time, what, got, want);
        end
    endtask

    function automatic logic [63:0] freshness_q(input logic [31:0] age, input logic [31:0] ttl);
        if (ttl == 32'd0) return 64'd1 << FRAC_BITS;
        if (age >= ttl) return 64'd0;
        return ({32'd0, ttl - age} << FRAC_BITS) / {32'd0, ttl};
    endfunction

    function automatic in_item_t unpack_request(input logic [167:0] d);
        in_item_t r;
        r.now_time       = d[31:0];
        r.telemetry_time = d[63:32];
        r.range_time     = d[95:64];
        r.peer_present   = d[96];
        r.gnss_ok        = d[97];
        r.fix_kind       = d[100:98];
        r.range_ok       = d[101];
        r.range_dist     = d[133:102];
        r.range_sigma    = d[165:134];
        return r;
    endfunction

    function automatic score_t score_report(input in_item_t r, input cfg_t c);
        logic [31:0] t_age;
        logic [31:0] r_age;
        logic [63:0] one_q;
        logic [63:0] tq;
        logic [63:0] rq;
        logic [63:0] prod;
        reject_t     code;
        score_t      s;
        t_age = r.now_time - r.telemetry_time;
        r_age = r.now_time - r.range_time;
        code  = REJ_NONE;
        if (!r.peer_present) begin
            code = REJ_TELEMETRY;
        end else if (c.telemetry_ttl != 32'd0 && t_age > c.telemetry_ttl) begin
            code = REJ_TELEMETRY;
        end else if (c.range_ttl != 32'd0 && r_age > c.range_ttl) begin
            code = REJ_RANGE;
        end else if (!r.gnss_ok || r.fix_kind < c.min_fix) begin
            code = REJ_GNSS;
        end else if (!r.range_ok || r.range_dist == 32'd0) begin
            code = REJ_RANGE;
        end else if (c.max_sigma != 32'd0 && r.range_sigma > c.max_sigma) begin
            code = REJ_SIGMA;
        end
        s = '0;
        s.code = code;
        if (code == REJ_NONE) begin
            one_q = 64'd1 << FRAC_BITS;
            tq    = freshness_q(t_age, c.telemetry_ttl);
            rq    = freshness_q(r_age, c.range_ttl);
            prod  = (tq * rq) >> FRAC_BITS;
            s.gnss_score      = one_q[SW-1:0];
            s.telemetry_score = tq[SW-1:0];
            s.range_score     = rq[SW-1:0];
            s.total_score     = prod[SW-1:0];
        end
        return s;
    endfunction

    function automatic logic [31:0] register_value(input reg_idx_t idx);
        case (idx)
            REG_TELEMETRY_TTL: return gate_cfg.telemetry_ttl;
            REG_RANGE_TTL:     return gate_cfg.range_ttl;
            REG_MAX_SIGMA:     return gate_cfg.max_sigma;
            default:           return {29'd0, gate_cfg.min_fix};
        endcase
    endfunction

    always @(posedge aclk) begin
        score_t got;
        score_t want;
        if (!aresetn) begin
            gate_cfg.telemetry_ttl = 32'd0;
            gate_cfg.range_ttl     = 32'd0;
            gate_cfg.max_sigma     = 32'd0;
            gate_cfg.min_fix       = MIN_FIX_RESET;
            expected_scores.delete();
        end else begin
            if (psel && penable && pready && !pwrite) begin
                if (prdata !== register_value(reg_idx_t'(paddr[3:2]))) begin
                    report($sformatf("prdata of register %0d", paddr[3:2]), 64'(prdata),
                           64'(register_value(reg_idx_t'(paddr[3:2]))));
                end
            end
            if (psel && penable && pready && pwrite) begin
                case (reg_idx_t'(paddr[3:2]))
                    REG_TELEMETRY_TTL: gate_cfg.telemetry_ttl = pwdata;
                    REG_RANGE_TTL:     gate_cfg.range_ttl     = pwdata;
                    REG_MAX_SIGMA:     gate_cfg.max_sigma     = pwdata;
                    REG_MIN_FIX:       gate_cfg.min_fix       = pwdata[2:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                expected_scores.push_back(score_report(unpack_request(s_tdata), gate_cfg));
            end
            if (m_tvalid && m_tready) begin
                got.gnss_score      = m_tdata[SW-1:0];
                got.telemetry_score = m_tdata[2*SW-1:SW];
                got.range_score     = m_tdata[3*SW-1:2*SW];
                got.total_score     = m_tdata[4*SW-1:3*SW];
                got.code            = reject_t'(m_tdata[4*SW+2:4*SW]);
                if (expected_scores.size() == 0) begin
                    report("result without a pending request", m_tdata[63:0], 64'd0);
                end else begin
                    want = expected_scores.pop_front();
                    if (got.gnss_score !== want.gnss_score)
                        report("gnss_score", 64'(got.gnss_score), 64'(want.gnss_score));
                    if (got.telemetry_score !== want.telemetry_score)
                        report("telemetry_score", 64'(got.telemetry_score),
                               64'(want.telemetry_score));
                    if (got.range_score !== want.range_score)
                        report("range_score", 64'(got.range_score), 64'(want.range_score));
                    if (got.total_score !== want.total_score)
                        report("total_score", 64'(got.total_score), 64'(want.total_score));
                    if (got.code !== want.code)
                        report("reject_code", 64'(got.code), 64'(want.code));
                end
            end
        end
        pending_count = expected_scores.size();
    end

endmodule

[sim/tb_top.sv]
// Testbench top for the anchor quality gate: clock, reset, register setup, requests and verdict.
`timescale 1ns / 1ps

module tb_top;
    import aqg_pkg::*;

    localparam int FRAC_BITS   = 16;
    localparam int MW          = ((4*(FRAC_BITS+1)+3+7)/8)*8;
    localparam int SETTLE      = FRAC_BITS + 3 + 12;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 160;

    logic          aclk;
    logic          aresetn;
    logic          psel;
    logic          penable;
    logic          pwrite;
    logic [3:0]    paddr;
    logic [31:0]   pwdata;
    logic [31:0]   prdata;
    logic          pready;
    logic          s_tvalid;
    logic          s_tready;
    logic [167:0]  s_tdata;
    logic          m_tvalid;
    logic          m_tready;
    logic [MW-1:0] m_tdata;

    int   gate_errors;
    int   gate_pending;
    int   cycle_count;
    int   hold_requests;
    bit   tx_eager;
    bit   rx_eager;
    cfg_t stim_cfg;
    cfg_t phase_cfg[PHASES];

    anchor_quality_gate #(.FRAC_BITS(FRAC_BITS)) uut (
        .aclk(aclk), .aresetn(aresetn),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    aqg_checker #(.FRAC_BITS(FRAC_BITS)) gate_checker (
        .aclk(aclk), .aresetn(aresetn),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .mismatch_count(gate_errors), .pending_count(gate_pending)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        cycle_count = 0;
        forever begin
            @(posedge aclk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT) begin
                $display("anchor_quality_gate verification failed");
                $finish;
            end
        end
    end

    // The result side stalls at random; a hold request keeps it stalled long enough to fill the block.
    initial begin : result_sink
        int stall;
        int holds_served;
        m_tready = 1'b0;
        holds_served = 0;
        @(negedge aclk);
        forever begin
            if (hold_requests > holds_served) begin
                stall = 300;
                holds_served++;
            end else begin
                stall = rx_eager ? 0 : $urandom_range(0, 9);
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            @(negedge aclk);
        end
    end

    function automatic cfg_t make_cfg(input logic [31:0] t_ttl, input logic [31:0] r_ttl,
                                      input logic [31:0] sigma, input logic [2:0] fix);
        cfg_t c;
        c.telemetry_ttl = t_ttl;
        c.range_ttl     = r_ttl;
        c.max_sigma     = sigma;
        c.min_fix       = fix;
        return c;
    endfunction

    function automatic logic [167:0] pack_request(input in_item_t r);
        return {2'b00, r.range_sigma, r.range_dist, r.range_ok, r.fix_kind, r.gnss_ok,
                r.peer_present, r.range_time, r.telemetry_time, r.now_time};
    endfunction

    function automatic in_item_t make_request(input logic [31:0] now, input logic [31:0] t_age,
                                              input logic [31:0] r_age);
        in_item_t r;
        r.now_time       = now;
        r.telemetry_time = now - t_age;
        r.range_time     = now - r_age;
        r.peer_present   = 1'b1;
        r.gnss_ok        = 1'b1;
        r.fix_kind       = 3'd5;
        r.range_ok       = 1'b1;
        r.range_dist     = 32'd1500;
        r.range_sigma    = 32'd100;
        return r;
    endfunction

    function automatic logic [31:0] pick_age(input logic [31:0] ttl);
        int k;
        k = $urandom_range(0, 19);
        if (ttl == 32'd0 || k == 0) return $urandom;
        if (k == 1) return ttl;
        if (k == 2) return ttl + 32'd1;
        if (k == 3) return 32'd0;
        if (k == 4) return ttl + $urandom_range(1, 1000);
        return $urandom_range(0, ttl);
    endfunction

    function automatic in_item_t random_request(input cfg_t c);
        in_item_t r;
        int k;
        if ($urandom_range(0, 99) < 8) begin
            r.now_time       = $urandom;
            r.telemetry_time = $urandom;
            r.range_time     = $urandom;
            r.peer_present   = 1'($urandom_range(0, 1));
            r.gnss_ok        = 1'($urandom_range(0, 1));
            r.fix_kind       = 3'($urandom_range(0, 7));
            r.range_ok       = 1'($urandom_range(0, 1));
            r.range_dist     = $urandom;
            r.range_sigma    = $urandom;
            return r;
        end
        r = make_request($urandom, pick_age(c.telemetry_ttl), pick_age(c.range_ttl));
        r.peer_present = ($urandom_range(0, 99) < 96);
        r.gnss_ok      = ($urandom_range(0, 99) < 93);
        r.fix_kind     = 3'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 7)
                                                         : $urandom_range(c.min_fix, 7));
        r.range_ok     = ($urandom_range(0, 99) < 94);
        k = $urandom_range(0, 19);
        r.range_dist = (k == 0) ? 32'd0 : (k == 1) ? 32'hFFFF_FFFF : $urandom;
        k = $urandom_range(0, 9);
        if (c.max_sigma == 32'd0 || k == 2) r.range_sigma = $urandom;
        else if (k == 0) r.range_sigma = c.max_sigma;
        else if (k == 1) r.range_sigma = c.max_sigma + 32'd1;
        else r.range_sigma = $urandom_range(0, c.max_sigma);
        return r;
    endfunction

    task automatic send_item(input in_item_t r);
        int gap;
        gap = tx_eager ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pack_request(r);
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    // Leaves the bus in its access state; the caller returns it to idle after the last transfer.
    task automatic apb_access(input reg_idx_t idx, input logic wr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
    endtask

    task automatic read_registers();
        apb_access(REG_TELEMETRY_TTL, 1'b0, 32'd0);
        apb_access(REG_RANGE_TTL, 1'b0, 32'd0);
        apb_access(REG_MAX_SIGMA, 1'b0, 32'd0);
        apb_access(REG_MIN_FIX, 1'b0, 32'd0);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic program_config(input cfg_t c);
        logic [31:0] fix_word;
        fix_word = $urandom;
        fix_word[2:0] = c.min_fix;
        apb_access(REG_TELEMETRY_TTL, 1'b1, c.telemetry_ttl);
        apb_access(REG_RANGE_TTL, 1'b1, c.range_ttl);
        apb_access(REG_MAX_SIGMA, 1'b1, c.max_sigma);
        apb_access(REG_MIN_FIX, 1'b1, fix_word);
        read_registers();
        stim_cfg = c;
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (gate_pending != 0) @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
    endtask

    initial begin
        in_item_t r;
        aresetn       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        hold_requests = 0;
        tx_eager      = 1'b0;
        rx_eager      = 1'b0;
        stim_cfg      = make_cfg(32'd0, 32'd0, 32'd0, MIN_FIX_RESET);
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Reset settings: both freshness checks and the sigma check are off.
        read_registers();
        @(negedge aclk);
        r = make_request(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000); send_item(r);
        r = '1; send_item(r);
        r = '0; send_item(r);
        r = make_request(32'd100, 32'd10, 32'd10); r.fix_kind = 3'd2; send_item(r);
        drain_results();

        program_config(make_cfg(32'd1000, 32'd500, 32'd200, 3'd3));
        @(negedge aclk);
        r = make_request(32'd5000, 32'd0, 32'd0); send_item(r);
        r = make_request(32'd5000, 32'd1000, 32'd0); send_item(r);
        r = make_request(32'd5000, 32'd1001, 32'd0); send_item(r);
        r = make_request(32'd5000, 32'd0, 32'd500); send_item(r);
        r = make_request(32'd5000, 32'd0, 32'd501); send_item(r);
        r = make_request(32'd5000, 32'd2000, 32'd0); r.peer_present = 1'b0; send_item(r);
        r = make_request(32'd5000, 32'd2000, 32'd900); send_item(r);
        r = make_request(32'd5000, 32'd0, 32'd900); r.gnss_ok = 1'b0; send_item(r);
        r = make_request(32'd5000, 32'd0, 32'd0); r.gnss_ok = 1'b0; send_item(r);
        r = make_request(32'd5000, 32'd10, 32'd10); r.fix_kind = 3'd2; send_item(r);
        r = make_request(32'd5000, 32'd10, 32'd10); r.fix_kind = 3'd3; send_item(r);
        r = make_request(32'd5000, 32'd0, 32'd0); r.gnss_ok = 1'b0; r.range_ok = 1'b0;
        send_item(r);
        r = make_request(32'd5000, 32'd0, 32'd0); r.range_ok = 1'b0; send_item(r);
        r = make_request(32'd5000, 32'd0, 32'd0); r.range_dist = 32'd0; send_item(r);
        r = make_request(32'd5000, 32'd0, 32'd0); r.range_dist = 32'd0;
        r.range_sigma = 32'd300; send_item(r);
        r = make_request(32'd5000, 32'd0, 32'd0); r.range_sigma = 32'd201; send_item(r);
        r = make_request(32'd5000, 32'd0, 32'd0); r.range_sigma = 32'd200; send_item(r);
        r = make_request(32'd5, 32'd106, 32'd250); send_item(r);
        r = make_request(32'd123456, 32'd333, 32'd123); send_item(r);
        r = make_request(32'd5000, 32'hFFFF_FFF0, 32'd0); send_item(r);
        drain_results();

        phase_cfg[0] = make_cfg(32'd1000, 32'd500, 32'd200, 3'd3);
        phase_cfg[1] = make_cfg(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd0);
        phase_cfg[2] = make_cfg(32'd1, 32'd1, 32'd1, 3'd7);
        phase_cfg[3] = make_cfg(32'd0, 32'd3000, 32'd0, 3'd5);
        phase_cfg[4] = make_cfg($urandom_range(1, 100000), $urandom,
                                $urandom_range(1, 1000000), 3'($urandom_range(0, 7)));
        phase_cfg[5] = make_cfg(32'd50000, 32'd0, 32'd5000, 3'd1);
        phase_cfg[6] = make_cfg($urandom, $urandom, $urandom, 3'($urandom_range(0, 7)));
        phase_cfg[7] = make_cfg(32'd7, 32'd65536, 32'd100, 3'd4);

        for (int p = 0; p < PHASES; p++) begin
            program_config(phase_cfg[p]);
            @(negedge aclk);
            tx_eager = (p % 3 == 2);
            rx_eager = (p % 3 == 1);
            if (p == 2) hold_requests++;
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (p == 4 && i == PHASE_ITEMS / 2) begin
                    s_tvalid <= 1'b0;
                    while (gate_pending != 0) @(negedge aclk);
                end
                send_item(random_request(stim_cfg));
            end
            drain_results();
        end

        if (gate_errors == 0 && gate_pending == 0) begin
            $display("anchor_quality_gate verification clean");
        end else begin
            $display("anchor_quality_gate verification failed");
        end
        $finish;
    end

endmodule
